/* rtl/swrl_pkg.sv */
`default_nettype none

package swrl_pkg;

    localparam int MAX_PERIODS   = 64;
    localparam int COUNT_BITS    = 16;
    localparam int CATCHUP       = 2;

    localparam int TS_BITS       = 32;
    localparam int PER_BITS      = 16;
    localparam int WSET_BITS     = 7;
    localparam int EVT_BITS      = 16;
    localparam int OUT_TOT_BITS  = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    localparam int SLOT_BITS  = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
    localparam int WIN_BITS   = $clog2(MAX_PERIODS + 1);
    localparam int N_BITS     = $clog2(MAX_PERIODS + CATCHUP + 1);
    localparam int TOTAL_BITS = COUNT_BITS + SLOT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SECS_PER_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIODS_PER_WINDOW = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_EVENTS         = 2'd2;

    localparam logic [PER_BITS-1:0]  RST_SECS_PER_PERIOD    = PER_BITS'(60);
    localparam logic [WSET_BITS-1:0] RST_PERIODS_PER_WINDOW = WSET_BITS'(60);
    localparam logic [EVT_BITS-1:0]  RST_MAX_EVENTS         = EVT_BITS'(60);

    typedef struct packed {
        logic                start;
        logic [TS_BITS-1:0]  dividend;
        logic [PER_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [TS_BITS-1:0]  quotient;
        logic [PER_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/swrl_ram.sv */
`default_nettype none

module swrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/swrl_div.sv */
`default_nettype none

module swrl_div
    import swrl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_BITS = $clog2(TS_BITS + 1);

    logic [PER_BITS-1:0] rem_reg;
    logic [TS_BITS-1:0]  quo_reg;
    logic [PER_BITS-1:0] dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [PER_BITS:0]   trial;
    logic                fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[TS_BITS-1]} - {1'b0, dvs_reg};
    assign fits  = !trial[PER_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                cnt_reg  <= CNT_BITS'(TS_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= trial[PER_BITS-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[PER_BITS-2:0], quo_reg[TS_BITS-1]};
                end
                quo_reg <= {quo_reg[TS_BITS-2:0], fits};
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/sliding_window_rate_limiter.sv */
`default_nettype none

// Sliding-window counter rate limiter. Each request carries a timestamp in
// seconds; the block turns it into a period number, clears the buckets of the
// periods passed since the last request (at most the window plus two), sums
// the window's buckets and admits the request if the sum is below max_events,
// counting it in the current bucket. One result comes back per request. A
// request runs through the shared serial divider twice (timestamp / period
// length, then period / window size), clears buckets one at a time (0 to
// window + 2), sums the bucket RAM through its single read port, then updates
// and hands off. in_stall stays high meanwhile; a finished result waits in the
// output register while the next request is taken. cfg_ready is always high;
// write configuration only while no request is in flight. Buckets start at
// zero after reset with no clearing pass.
module sliding_window_rate_limiter
    import swrl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [TS_BITS-1:0]       timestamp_seconds,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          accepted,
    output logic [OUT_TOT_BITS-1:0]       window_total,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_TS,
        S_DIV_WIN,
        S_CLEAR,
        S_SUM,
        S_UPDATE,
        S_OUT
    } state_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t                 state_reg;

    logic [PER_BITS-1:0]    secs_reg;
    logic [WSET_BITS-1:0]   win_cfg_reg;
    logic [EVT_BITS-1:0]    max_reg;

    logic [TS_BITS-1:0]     last_reg;
    logic [N_BITS-1:0]      n_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   idx_reg;
    logic [WIN_BITS-1:0]    sum_addr_reg;
    logic                   pend_reg;
    logic [SLOT_BITS-1:0]   pend_addr_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [COUNT_BITS-1:0]  slot_cnt_reg;
    logic                   valid_reg [MAX_PERIODS];

    logic                   res_acc_reg;
    logic [OUT_TOT_BITS-1:0] res_total_reg;
    logic                   out_valid_reg;
    logic                   accepted_reg;
    logic [OUT_TOT_BITS-1:0] window_total_reg;

    logic [PER_BITS-1:0]    secs_eff;
    logic [WIN_BITS-1:0]    win_eff;
    logic [N_BITS-1:0]      catch_lim;
    logic [TS_BITS:0]       diff;
    logic [N_BITS-1:0]      n_new;
    logic                   in_take;
    logic                   out_free;
    logic                   issue;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic                   ok;
    logic                   ram_we;
    logic [SLOT_BITS-1:0]   ram_waddr;
    logic [COUNT_BITS-1:0]  ram_wdata;
    logic [SLOT_BITS-1:0]   ram_raddr;
    logic [COUNT_BITS-1:0]  ram_rdata;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    always_comb
    begin
        secs_eff = (secs_reg == '0) ? PER_BITS'(1) : secs_reg;
        if (win_cfg_reg == '0)
        begin
            win_eff = WIN_BITS'(1);
        end
        else if (32'(win_cfg_reg) > 32'(MAX_PERIODS))
        begin
            win_eff = WIN_BITS'(MAX_PERIODS);
        end
        else
        begin
            win_eff = WIN_BITS'(win_cfg_reg);
        end
    end

    assign catch_lim = N_BITS'(win_eff) + N_BITS'(CATCHUP);

    // periods to clear: none when time stands or goes back, else bounded
    assign diff = {1'b0, div_rsp.quotient} - {1'b0, last_reg};
    always_comb
    begin
        if (diff[TS_BITS] || diff == '0)
        begin
            n_new = '0;
        end
        else if (diff > (TS_BITS + 1)'(catch_lim))
        begin
            n_new = catch_lim;
        end
        else
        begin
            n_new = diff[N_BITS-1:0];
        end
    end

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign issue    = (state_reg == S_SUM) && (sum_addr_reg < win_eff);
    assign rd_cnt   = valid_reg[pend_addr_reg] ? ram_rdata : '0;
    assign ok       = 32'(total_reg) < 32'(max_reg);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = timestamp_seconds;
        div_req.divisor  = secs_eff;
        if (state_reg == S_IDLE)
        begin
            div_req.start = in_take;
        end
        else if (state_reg == S_DIV_TS)
        begin
            div_req.start    = div_rsp.done;
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = PER_BITS'(win_eff);
        end
    end

    assign ram_raddr = sum_addr_reg[SLOT_BITS-1:0];
    assign ram_we    = (state_reg == S_UPDATE) && ok && (slot_cnt_reg != COUNT_MAX);
    assign ram_waddr = slot_reg;
    assign ram_wdata = slot_cnt_reg + COUNT_BITS'(1);

    swrl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    swrl_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_PERIODS)
    ) u_buckets (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            secs_reg         <= RST_SECS_PER_PERIOD;
            win_cfg_reg      <= RST_PERIODS_PER_WINDOW;
            max_reg          <= RST_MAX_EVENTS;
            last_reg         <= '0;
            n_reg            <= '0;
            slot_reg         <= '0;
            idx_reg          <= '0;
            sum_addr_reg     <= '0;
            pend_reg         <= 1'b0;
            pend_addr_reg    <= '0;
            total_reg        <= '0;
            slot_cnt_reg     <= '0;
            res_acc_reg      <= 1'b0;
            res_total_reg    <= '0;
            out_valid_reg    <= 1'b0;
            accepted_reg     <= 1'b0;
            window_total_reg <= '0;
            for (int i = 0; i < MAX_PERIODS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SECS_PER_PERIOD:    secs_reg    <= cfg_data[PER_BITS-1:0];
                    CFG_PERIODS_PER_WINDOW: win_cfg_reg <= cfg_data[WSET_BITS-1:0];
                    CFG_MAX_EVENTS:         max_reg     <= cfg_data[EVT_BITS-1:0];
                    default:                ;
                endcase
            end

            // the hand-off state reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            pend_reg      <= issue;
            pend_addr_reg <= sum_addr_reg[SLOT_BITS-1:0];

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= S_DIV_TS;
                    end
                end
                S_DIV_TS:
                begin
                    if (div_rsp.done)
                    begin
                        n_reg     <= n_new;
                        last_reg  <= div_rsp.quotient;
                        state_reg <= S_DIV_WIN;
                    end
                end
                S_DIV_WIN:
                begin
                    if (div_rsp.done)
                    begin
                        slot_reg     <= div_rsp.remainder[SLOT_BITS-1:0];
                        idx_reg      <= div_rsp.remainder[SLOT_BITS-1:0];
                        sum_addr_reg <= '0;
                        total_reg    <= '0;
                        slot_cnt_reg <= '0;
                        state_reg    <= (n_reg == '0) ? S_SUM : S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    // walk back from the current slot, wrapping at the window
                    valid_reg[idx_reg] <= 1'b0;
                    idx_reg <= (idx_reg == '0) ? SLOT_BITS'(win_eff - WIN_BITS'(1))
                                               : idx_reg - SLOT_BITS'(1);
                    n_reg <= n_reg - N_BITS'(1);
                    if (n_reg == N_BITS'(1))
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    if (issue)
                    begin
                        sum_addr_reg <= sum_addr_reg + WIN_BITS'(1);
                    end
                    if (pend_reg)
                    begin
                        total_reg <= total_reg + TOTAL_BITS'(rd_cnt);
                        if (pend_addr_reg == slot_reg)
                        begin
                            slot_cnt_reg <= rd_cnt;
                        end
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (ram_we)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                    end
                    res_acc_reg   <= ok;
                    res_total_reg <= (32'(total_reg) > 32'(16'hFFFF))
                                     ? OUT_TOT_BITS'(16'hFFFF)
                                     : OUT_TOT_BITS'(total_reg);
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        accepted_reg     <= res_acc_reg;
                        window_total_reg <= res_total_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign window_total = window_total_reg;

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (n_reg != '0))
        else $error("clear walk entered with nothing to clear");

    a_clear_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (WIN_BITS'(idx_reg) < win_eff))
        else $error("clear index outside the window");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_TS || state_reg == S_DIV_WIN))
        else $error("divider finished outside a divide step");

    a_sum_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> (!pend_reg && $past(state_reg) == S_SUM))
        else $error("update reached with a bucket read in flight");

endmodule

`default_nettype wire

/* test/tb_sliding_window_rate_limiter.sv */
module tb_sliding_window_rate_limiter;
    import swrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int RANDOM_ITEMS   = 1530;
    localparam int RANDOM_PHASES  = 15;

    typedef struct packed {
        logic                    admitted;
        logic [OUT_TOT_BITS-1:0] total;
    } verdict_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [TS_BITS-1:0]       timestamp_seconds;
    logic                     out_valid;
    logic                     out_stall;
    logic                     accepted;
    logic [OUT_TOT_BITS-1:0]  window_total;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // shadow of the limiter: settings, last period and the bucket array
    logic [PER_BITS-1:0]   per_len;
    logic [WSET_BITS-1:0]  win_setting;
    logic [EVT_BITS-1:0]   event_cap;
    logic [TS_BITS-1:0]    last_period_seen;
    logic [COUNT_BITS-1:0] bucket_count [MAX_PERIODS];

    verdict_t    pending_verdicts [$];
    int unsigned in_gap_max;
    int unsigned out_gap_max;
    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_admitted;
    int unsigned n_rejected;
    int unsigned n_cfg_writes;
    int unsigned quiet_cycles = 0;

    sliding_window_rate_limiter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .timestamp_seconds (timestamp_seconds),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .accepted          (accepted),
        .window_total      (window_total),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clear stale periods, sum the window and decide on one request.
    function automatic void admit_event(input logic [TS_BITS-1:0] ts,
                                        output logic admit,
                                        output logic [OUT_TOT_BITS-1:0] total);
        longint unsigned span;
        longint unsigned cur;
        longint unsigned from;
        longint unsigned p;
        longint unsigned sum;
        longint unsigned slot;

        span = (win_setting == 0) ? 1 : ((win_setting > MAX_PERIODS) ? MAX_PERIODS : win_setting);
        cur  = ts / ((per_len == 0) ? 1 : per_len);
        from = last_period_seen;
        if (cur > from + span + CATCHUP)
            from = cur - span - CATCHUP;
        for (p = from + 1; p <= cur; p++)
            bucket_count[p % span] = '0;
        last_period_seen = cur[TS_BITS-1:0];
        slot = cur % span;
        sum = 0;
        for (int i = 0; i < span; i++)
            sum += bucket_count[i];
        admit = (sum < event_cap);
        if (admit && bucket_count[slot] != {COUNT_BITS{1'b1}})
            bucket_count[slot] = bucket_count[slot] + 1'b1;
        total = (sum > 16'hFFFF) ? 16'hFFFF : sum[OUT_TOT_BITS-1:0];
    endfunction

    task automatic send_request(input logic [TS_BITS-1:0] ts);
        int unsigned gap;
        verdict_t v;

        gap = $urandom_range(0, in_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        timestamp_seconds <= ts;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        admit_event(ts, v.admitted, v.total);
        pending_verdicts.push_back(v);
        n_requests++;
    endtask

    // drop valid and hold until every outstanding request has its result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
    endtask

    task automatic program_limits(input logic [PER_BITS-1:0] spp,
                                  input logic [CFG_DATA_BITS-1:0] ppw,
                                  input logic [EVT_BITS-1:0] cap);
        logic [CFG_IDX_BITS-1:0]  idx [3];
        logic [CFG_DATA_BITS-1:0] val [3];

        idx[0] = CFG_SECS_PER_PERIOD;    val[0] = spp;
        idx[1] = CFG_PERIODS_PER_WINDOW; val[1] = ppw;
        idx[2] = CFG_MAX_EVENTS;         val[2] = cap;
        drain_results();
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (idx[i])
                CFG_SECS_PER_PERIOD:    per_len     = val[i][PER_BITS-1:0];
                CFG_PERIODS_PER_WINDOW: win_setting = val[i][WSET_BITS-1:0];
                CFG_MAX_EVENTS:         event_cap   = val[i][EVT_BITS-1:0];
                default: ;
            endcase
            n_cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_settings();
        send_request(32'd0);
        send_request(32'd59);
        send_request(32'hFFFF_FFFF);
        // backwards: nothing cleared, the far bucket still counts
        send_request(32'd0);
    endtask

    task automatic test_setting_extremes();
        // zero period length, zero window, zero cap: reject everything
        program_limits(16'd0, 16'd0, 16'd0);
        send_request(32'd5);
        send_request(32'd5);
        // widest settings, window register above the bucket count
        program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(32'hFFFF_FFFF);
        send_request(32'h0000_FFFF);
    endtask

    task automatic test_limit_reached();
        program_limits(16'd1, 16'd4, 16'd3);
        repeat (4) send_request(32'd100);
        send_request(32'd101);
        send_request(32'd104);
        program_limits(16'd1, 16'd1, 16'd1);
        send_request(32'd7);
        send_request(32'd7);
    endtask

    task automatic test_window_resize();
        program_limits(16'd10, 16'd8, 16'd100);
        send_request(32'd0);
        send_request(32'd30);
        send_request(32'd50);
        send_request(32'd70);
        // shrink: only the low slots are summed, the rest keep their counts
        program_limits(16'd10, 16'd2, 16'd100);
        send_request(32'd75);
        send_request(32'd20);
        program_limits(16'd10, 16'd8, 16'd100);
        send_request(32'd25);
    endtask

    task automatic test_random_traffic();
        logic [PER_BITS-1:0]      spp;
        logic [WSET_BITS-1:0]     w7;
        logic [EVT_BITS-1:0]      cap;
        logic [TS_BITS-1:0]       ts;
        int unsigned              step_max;
        int unsigned              per_eff;
        int unsigned              r;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0: spp = 16'd0;
                1: spp = 16'd1;
                2: spp = PER_BITS'($urandom_range(1, 8));
                3: spp = 16'hFFFF;
                4: spp = PER_BITS'($urandom_range(0, 65535));
                default: spp = PER_BITS'($urandom_range(2, 120));
            endcase
            case ($urandom_range(0, 5))
                0: w7 = 7'd0;
                1: w7 = 7'd1;
                2: w7 = 7'd64;
                3: w7 = WSET_BITS'($urandom_range(65, 127));
                default: w7 = WSET_BITS'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 5))
                0: cap = 16'd0;
                1: cap = 16'd1;
                2: cap = EVT_BITS'($urandom_range(1, 16));
                3: cap = 16'hFFFF;
                4: cap = EVT_BITS'($urandom_range(0, 65535));
                default: cap = EVT_BITS'($urandom_range(0, 300));
            endcase
            program_limits(spp, (16'($urandom) & 16'hFF80) | 16'(w7), cap);
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            per_eff  = (spp == 0) ? 1 : spp;
            step_max = $urandom_range(0, 1) ? per_eff / 4 : per_eff * 2;
            case ($urandom_range(0, 2))
                0: ts = $urandom;
                1: ts = 32'hFFFF_FFFF - $urandom_range(0, 5000);
                default: ts = $urandom_range(0, 5000);
            endcase
            for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    ts = ts + $urandom_range(0, step_max);
                else if (r < 90)
                    ts = $urandom;
                else
                    ts = ts - $urandom_range(1, per_eff * 4);
                send_request(ts);
                if (k % 50 == 49)
                    drain_results();
            end
        end
    endtask

    // result side: stall for a drawn number of valid cycles, then take and check
    initial
    begin
        int unsigned hold;
        verdict_t want;

        out_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result with no request outstanding: accepted=%0b window_total=%0d",
                           accepted, window_total);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (want.admitted) n_admitted++; else n_rejected++;
                    if (accepted !== want.admitted)
                    begin
                        $error("accepted: expected %0b, got %0b", want.admitted, accepted);
                        errors++;
                    end
                    if (window_total !== want.total)
                    begin
                        $error("window_total: expected %0d, got %0d", want.total, window_total);
                        errors++;
                    end
                end
                hold = $urandom_range(0, out_gap_max);
                if (hold != 0)
                    out_stall <= 1'b1;
            end
            else if (out_valid && out_stall)
            begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("** sliding_window_rate_limiter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        timestamp_seconds = '0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_SECS_PER_PERIOD;
        cfg_data          = '0;
        errors            = 0;
        n_requests        = 0;
        n_admitted        = 0;
        n_rejected        = 0;
        n_cfg_writes      = 0;
        in_gap_max        = 8;
        out_gap_max       = 8;
        per_len           = RST_SECS_PER_PERIOD;
        win_setting       = RST_PERIODS_PER_WINDOW;
        event_cap         = RST_MAX_EVENTS;
        last_period_seen  = '0;
        for (int i = 0; i < MAX_PERIODS; i++)
            bucket_count[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_setting_extremes();
        test_limit_reached();
        test_window_resize();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", pending_verdicts.size());
            errors++;
        end
        $display("Sent %0d timestamped requests (%0d admitted, %0d rejected) over %0d setting writes,",
                 n_requests, n_admitted, n_rejected, n_cfg_writes);
        $display("covering catch-up, backwards time, window resizing and limit edges.");
        if (errors == 0)
            $display("** sliding_window_rate_limiter: PASSED **");
        else
            $display("** sliding_window_rate_limiter: FAILED **");
        $finish;
    end

endmodule
